FILE: rtl/isb_pkg.sv
// ----------------------------------------------------------------------------
// isb_pkg
// Shared types, codes and sizes for the indexed sequence buffer.
// ----------------------------------------------------------------------------
package isb_pkg;

    // List storage size, derived address width and fixed widths
    localparam int CAPACITY = 64;
    localparam int ADDR_W   = $clog2(CAPACITY);
    localparam int CNT_W    = 7;
    localparam int WORD_W   = 64;

    // Command codes
    localparam logic [3:0] CMD_APPEND     = 4'd0;
    localparam logic [3:0] CMD_DROP_LAST  = 4'd1;
    localparam logic [3:0] CMD_INSERT_AT  = 4'd2;
    localparam logic [3:0] CMD_REMOVE_AT  = 4'd3;
    localparam logic [3:0] CMD_READ_FIRST = 4'd4;
    localparam logic [3:0] CMD_READ_LAST  = 4'd5;
    localparam logic [3:0] CMD_READ_AT    = 4'd6;
    localparam logic [3:0] CMD_REVERSE    = 4'd7;
    localparam logic [3:0] CMD_CLEAR      = 4'd8;
    localparam logic [3:0] CMD_FILL       = 4'd9;

    // Status codes
    localparam logic [1:0] ST_DONE  = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;
    localparam logic [1:0] ST_EMPTY = 2'd3;

    // Command transaction
    typedef struct packed {
        logic [3:0]        command;
        logic [WORD_W-1:0] value;
        logic [CNT_W-1:0]  position;
        logic [CNT_W-1:0]  fill_count;
    } t_isb_in;

    // Result transaction
    typedef struct packed {
        logic [WORD_W-1:0] read_word;
        logic [CNT_W-1:0]  length;
        logic              is_empty;
        logic [1:0]        status;
    } t_isb_out;

endpackage

FILE: rtl/isb_fill_gen.sv
// ----------------------------------------------------------------------------
// isb_fill_gen
// Converts a small entry index into its binary64 bit pattern for refills.
// ----------------------------------------------------------------------------
module isb_fill_gen import isb_pkg::*; (
    input  logic [ADDR_W-1:0] i_index,
    output logic [WORD_W-1:0] o_word
);

    logic [ADDR_W-1:0] w_exp;
    logic [52:0]       w_shift;

    // Find the leading one of the index
    always_comb begin
        w_exp = '0;
        for (int b = 1; b < ADDR_W; b++) begin
            if (i_index[b]) begin
                w_exp = ADDR_W'(b);
            end
        end
    end

    // Align the leading one to the hidden bit and drop it
    assign w_shift = 53'(i_index) << (6'd52 - 6'(w_exp));

    always_comb begin
        if (i_index == '0) begin
            o_word = '0;
        end else begin
            o_word = {1'b0, 11'd1023 + 11'(w_exp), w_shift[51:0]};
        end
    end

endmodule

FILE: rtl/indexed_sequence_buffer.sv
// ----------------------------------------------------------------------------
// indexed_sequence_buffer
// Bounded ordered list of 64-bit words in one single-port-read memory,
// driven by a small sequencer that steps index counters over the list.
// ----------------------------------------------------------------------------
// Commands are taken only in the idle state; the input stalls while one is
// in progress and until its result has been loaded into the output register,
// so a new command is taken only once the previous result is loaded.
// Reset clears the length and all control; list contents are not cleared.
// ----------------------------------------------------------------------------
module indexed_sequence_buffer import isb_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_stall,
    input  t_isb_in  i_in_data,
    output logic     o_out_valid,
    input  logic     i_out_stall,
    output t_isb_out o_out_data
);

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_INS_RD  = 4'd1;
    localparam logic [3:0] S_INS_WR  = 4'd2;
    localparam logic [3:0] S_INS_PUT = 4'd3;
    localparam logic [3:0] S_REM_RD  = 4'd4;
    localparam logic [3:0] S_REM_WR  = 4'd5;
    localparam logic [3:0] S_RD_CAP  = 4'd6;
    localparam logic [3:0] S_RV_LO   = 4'd7;
    localparam logic [3:0] S_RV_HI   = 4'd8;
    localparam logic [3:0] S_RV_WLO  = 4'd9;
    localparam logic [3:0] S_RV_WHI  = 4'd10;
    localparam logic [3:0] S_FILL    = 4'd11;
    localparam logic [3:0] S_DONE    = 4'd12;

    localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

    logic [WORD_W-1:0] mem [CAPACITY];

    logic [3:0]        r_state, n_state;
    t_isb_in           r_req, n_req;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic [CNT_W-1:0]  r_j, n_j;
    logic [CNT_W-1:0]  r_hi, n_hi;
    logic [WORD_W-1:0] r_tmp, n_tmp;
    logic [WORD_W-1:0] r_word, n_word;
    logic [1:0]        r_status, n_status;
    logic [WORD_W-1:0] r_rdata;
    t_isb_out          r_out;
    logic              r_out_valid;

    logic              w_accept;
    logic              w_out_free;
    logic              w_we;
    logic [ADDR_W-1:0] w_waddr;
    logic [ADDR_W-1:0] w_raddr;
    logic [WORD_W-1:0] w_wdata;
    logic [WORD_W-1:0] w_fill_word;
    logic [CNT_W-1:0]  w_jm1;
    logic [CNT_W-1:0]  w_cm1;
    logic [CNT_W-1:0]  w_fc;

    assign o_in_stall  = (r_state != S_IDLE);
    assign w_accept    = i_in_valid && !o_in_stall;
    assign w_out_free  = !r_out_valid || !i_out_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    assign w_jm1 = r_j - 1'b1;
    assign w_cm1 = r_cnt - 1'b1;
    assign w_fc  = (i_in_data.fill_count > CAP_CNT) ? CAP_CNT : i_in_data.fill_count;

    isb_fill_gen u_fill_gen (
        .i_index (r_j[ADDR_W-1:0]),
        .o_word  (w_fill_word)
    );

    // Sequencer: decode the command, then step the index over the list
    always_comb begin
        n_state  = r_state;
        n_req    = r_req;
        n_cnt    = r_cnt;
        n_j      = r_j;
        n_hi     = r_hi;
        n_tmp    = r_tmp;
        n_word   = r_word;
        n_status = r_status;
        w_we     = 1'b0;
        w_waddr  = r_j[ADDR_W-1:0];
        w_wdata  = r_rdata;
        w_raddr  = r_j[ADDR_W-1:0];

        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_req    = i_in_data;
                    n_word   = '0;
                    n_status = ST_DONE;
                    n_state  = S_DONE;
                    case (i_in_data.command) inside
                        CMD_APPEND: begin
                            if (r_cnt >= CAP_CNT) begin
                                n_status = ST_FULL;
                            end else begin
                                w_we    = 1'b1;
                                w_waddr = r_cnt[ADDR_W-1:0];
                                w_wdata = i_in_data.value;
                                n_cnt   = r_cnt + 1'b1;
                            end
                        end
                        CMD_DROP_LAST: begin
                            if (r_cnt == '0) begin
                                n_status = ST_EMPTY;
                            end else begin
                                n_cnt = w_cm1;
                            end
                        end
                        CMD_INSERT_AT: begin
                            if (i_in_data.position > r_cnt) begin
                                n_status = ST_RANGE;
                            end else if (r_cnt >= CAP_CNT) begin
                                n_status = ST_FULL;
                            end else begin
                                n_j     = r_cnt;
                                n_state = (i_in_data.position == r_cnt) ? S_INS_PUT
                                                                        : S_INS_RD;
                            end
                        end
                        CMD_REMOVE_AT: begin
                            if (i_in_data.position >= r_cnt) begin
                                n_status = ST_RANGE;
                            end else if (i_in_data.position == w_cm1) begin
                                n_cnt = w_cm1;
                            end else begin
                                n_j     = i_in_data.position;
                                n_state = S_REM_RD;
                            end
                        end
                        CMD_READ_FIRST, CMD_READ_LAST: begin
                            if (r_cnt == '0) begin
                                n_status = ST_EMPTY;
                            end else begin
                                w_raddr = (i_in_data.command == CMD_READ_FIRST) ? '0
                                          : w_cm1[ADDR_W-1:0];
                                n_state = S_RD_CAP;
                            end
                        end
                        CMD_READ_AT: begin
                            if (i_in_data.position >= r_cnt) begin
                                n_status = ST_RANGE;
                            end else begin
                                w_raddr = i_in_data.position[ADDR_W-1:0];
                                n_state = S_RD_CAP;
                            end
                        end
                        CMD_REVERSE: begin
                            if (r_cnt > CNT_W'(1)) begin
                                n_j     = '0;
                                n_hi    = w_cm1;
                                n_state = S_RV_LO;
                            end
                        end
                        CMD_CLEAR: begin
                            n_cnt = '0;
                        end
                        CMD_FILL: begin
                            if (w_fc == '0) begin
                                n_cnt = '0;
                            end else begin
                                n_j     = '0;
                                n_hi    = w_fc;
                                n_state = S_FILL;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            // Shift one entry up for insert
            S_INS_RD: begin
                w_raddr = w_jm1[ADDR_W-1:0];
                n_state = S_INS_WR;
            end
            S_INS_WR: begin
                w_we    = 1'b1;
                w_waddr = r_j[ADDR_W-1:0];
                n_j     = w_jm1;
                n_state = (w_jm1 == r_req.position) ? S_INS_PUT : S_INS_RD;
            end
            S_INS_PUT: begin
                w_we    = 1'b1;
                w_waddr = r_req.position[ADDR_W-1:0];
                w_wdata = r_req.value;
                n_cnt   = r_cnt + 1'b1;
                n_state = S_DONE;
            end
            // Shift one entry down for remove
            S_REM_RD: begin
                w_raddr = r_j[ADDR_W-1:0] + 1'b1;
                n_state = S_REM_WR;
            end
            S_REM_WR: begin
                w_we    = 1'b1;
                w_waddr = r_j[ADDR_W-1:0];
                n_j     = r_j + 1'b1;
                if (r_j + CNT_W'(2) >= r_cnt) begin
                    n_cnt   = w_cm1;
                    n_state = S_DONE;
                end else begin
                    n_state = S_REM_RD;
                end
            end
            S_RD_CAP: begin
                n_word  = r_rdata;
                n_state = S_DONE;
            end
            // Swap one pair for reverse
            S_RV_LO: begin
                w_raddr = r_j[ADDR_W-1:0];
                n_state = S_RV_HI;
            end
            S_RV_HI: begin
                w_raddr = r_hi[ADDR_W-1:0];
                n_tmp   = r_rdata;
                n_state = S_RV_WLO;
            end
            S_RV_WLO: begin
                w_we    = 1'b1;
                w_waddr = r_j[ADDR_W-1:0];
                n_state = S_RV_WHI;
            end
            S_RV_WHI: begin
                w_we    = 1'b1;
                w_waddr = r_hi[ADDR_W-1:0];
                w_wdata = r_tmp;
                n_j     = r_j + 1'b1;
                n_hi    = r_hi - 1'b1;
                n_state = (r_j + CNT_W'(2) < r_hi) ? S_RV_LO : S_DONE;
            end
            // Write one ascending entry for fill
            S_FILL: begin
                w_we    = 1'b1;
                w_waddr = r_j[ADDR_W-1:0];
                w_wdata = w_fill_word;
                n_j     = r_j + 1'b1;
                if (r_j + 1'b1 == r_hi) begin
                    n_cnt   = r_hi;
                    n_state = S_DONE;
                end
            end
            // Hand the result to the output register
            S_DONE: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Hold list contents and the registered read port
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            mem[w_waddr] <= w_wdata;
        end
        r_rdata <= mem[w_raddr];
    end

    // Advance control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    // Hold the working registers of the current transaction
    always_ff @(posedge i_clk) begin
        r_req    <= n_req;
        r_j      <= n_j;
        r_hi     <= n_hi;
        r_tmp    <= n_tmp;
        r_word   <= n_word;
        r_status <= n_status;
    end

    // Load the result transaction, drop it once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == S_DONE && w_out_free) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_DONE && w_out_free) begin
            r_out.read_word <= r_word;
            r_out.length    <= r_cnt;
            r_out.is_empty  <= (r_cnt == '0);
            r_out.status    <= r_status;
        end
    end

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CAP_CNT)
        else $error("list length above capacity");

    a_accept_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> r_state != S_IDLE)
        else $error("accepted command did not start");

    a_done_emits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && w_out_free) |=> (o_out_valid && r_state == S_IDLE))
        else $error("finished command produced no result");

    a_empty_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.is_empty == (o_out_data.length == '0)))
        else $error("empty flag disagrees with length");

endmodule

FILE: dv/tb_indexed_sequence_buffer.sv
// ----------------------------------------------------------------------------
// tb_indexed_sequence_buffer
// Self-checking bench for the indexed sequence buffer. A behavioral list
// predictor tracks contents and length for each accepted command transaction.
// The monitor compares every result transaction against the oldest prediction.
// Directed edge cases run first, then random traffic under three idling mixes.
// ----------------------------------------------------------------------------
module tb_indexed_sequence_buffer;
    import isb_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int         RUN_LIMIT        = 800_000;
    localparam int         DRAIN_CYCLES     = 160;
    localparam logic [3:0] CMD_FIRST_UNUSED = CMD_FILL + 4'd1;
    localparam logic [3:0] CMD_LAST_CODE    = 4'hF;

    logic     i_clk       = 1'b0;
    logic     i_rst_n     = 1'b0;
    logic     i_in_valid  = 1'b0;
    logic     o_in_stall;
    t_isb_in  i_in_data   = '0;
    logic     o_out_valid;
    logic     i_out_stall = 1'b0;
    t_isb_out o_out_data;

    // Predicted list contents and length
    logic [WORD_W-1:0] list_words [CAPACITY];
    int                list_length = 0;
    t_isb_out          expected_results [$];

    int in_idle_pct   = 0;
    int out_stall_pct = 0;
    int fail_count    = 0;
    int cycle_count   = 0;

    indexed_sequence_buffer dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    always #6 i_clk = ~i_clk;

    // Apply one command to the predicted list and form its result
    function automatic t_isb_out apply_list_command(input t_isb_in cmd);
        t_isb_out          res;
        logic [WORD_W-1:0] held;
        int                fill_n;
        res = '0;
        res.status = ST_DONE;
        case (cmd.command)
            CMD_APPEND: begin
                if (list_length >= CAPACITY) begin
                    res.status = ST_FULL;
                end else begin
                    list_words[list_length] = cmd.value;
                    list_length++;
                end
            end
            CMD_DROP_LAST: begin
                if (list_length == 0) res.status = ST_EMPTY;
                else list_length--;
            end
            CMD_INSERT_AT: begin
                // Range is checked ahead of fullness
                if (cmd.position > list_length) begin
                    res.status = ST_RANGE;
                end else if (list_length >= CAPACITY) begin
                    res.status = ST_FULL;
                end else begin
                    for (int k = list_length; k > cmd.position; k--)
                        list_words[k] = list_words[k-1];
                    list_words[cmd.position] = cmd.value;
                    list_length++;
                end
            end
            CMD_REMOVE_AT: begin
                if (cmd.position >= list_length) begin
                    res.status = ST_RANGE;
                end else begin
                    for (int k = cmd.position; k < list_length - 1; k++)
                        list_words[k] = list_words[k+1];
                    list_length--;
                end
            end
            CMD_READ_FIRST: begin
                if (list_length == 0) res.status = ST_EMPTY;
                else res.read_word = list_words[0];
            end
            CMD_READ_LAST: begin
                if (list_length == 0) res.status = ST_EMPTY;
                else res.read_word = list_words[list_length-1];
            end
            CMD_READ_AT: begin
                if (cmd.position >= list_length) res.status = ST_RANGE;
                else res.read_word = list_words[cmd.position];
            end
            CMD_REVERSE: begin
                for (int k = 0; k < list_length / 2; k++) begin
                    held = list_words[k];
                    list_words[k] = list_words[list_length-1-k];
                    list_words[list_length-1-k] = held;
                end
            end
            CMD_CLEAR: begin
                list_length = 0;
            end
            CMD_FILL: begin
                // Saturate the count, write 0.0, 1.0, 2.0, ...
                fill_n = (cmd.fill_count > CAPACITY) ? CAPACITY : int'(cmd.fill_count);
                for (int k = 0; k < fill_n; k++)
                    list_words[k] = $realtobits(real'(k));
                list_length = fill_n;
            end
            default: ;
        endcase
        res.length   = CNT_W'(list_length);
        res.is_empty = (list_length == 0);
        return res;
    endfunction

    function automatic t_isb_in make_command(input logic [3:0] code,
                                             input logic [WORD_W-1:0] word,
                                             input int pos, input int fc);
        t_isb_in cmd;
        cmd.command    = code;
        cmd.value      = word;
        cmd.position   = CNT_W'(pos);
        cmd.fill_count = CNT_W'(fc);
        return cmd;
    endfunction

    // Drive one command transaction and record its prediction on accept
    task automatic send_command(input t_isb_in cmd);
        while ($urandom_range(99) < in_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= cmd;
        do @(posedge i_clk); while (o_in_stall);
        expected_results.push_back(apply_list_command(cmd));
    endtask

    // Randomize the receiver stall every cycle
    always @(posedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < out_stall_pct);
    end

    // Compare each result transaction with the oldest prediction
    always @(posedge i_clk) begin
        t_isb_out want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_results.size() == 0) begin
                $error("unexpected result transaction: %h", o_out_data);
                fail_count++;
            end else begin
                want = expected_results.pop_front();
                if (o_out_data.read_word !== want.read_word) begin
                    $error("read_word: expected %h, got %h",
                           want.read_word, o_out_data.read_word);
                    fail_count++;
                end
                if (o_out_data.length !== want.length) begin
                    $error("length: expected %0d, got %0d", want.length, o_out_data.length);
                    fail_count++;
                end
                if (o_out_data.is_empty !== want.is_empty) begin
                    $error("is_empty: expected %b, got %b",
                           want.is_empty, o_out_data.is_empty);
                    fail_count++;
                end
                if (o_out_data.status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, o_out_data.status);
                    fail_count++;
                end
            end
        end
    end

    // Abort a hung run
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= RUN_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Empty list: drop, reads and remove all refuse
    task automatic test_empty_list();
        send_command(make_command(CMD_DROP_LAST, '0, 0, 0));
        send_command(make_command(CMD_READ_FIRST, '0, 0, 0));
        send_command(make_command(CMD_READ_LAST, '0, 0, 0));
        send_command(make_command(CMD_REMOVE_AT, '0, 127, 127));
    endtask

    // Append, insert at both ends, bad insert index, remove from the middle
    task automatic test_append_insert_remove();
        send_command(make_command(CMD_APPEND, {WORD_W{1'b1}}, 0, 0));
        send_command(make_command(CMD_APPEND, '0, 0, 0));
        send_command(make_command(CMD_INSERT_AT, 64'h5555_5555_5555_5555, 0, 0));
        send_command(make_command(CMD_INSERT_AT, 64'hAAAA_AAAA_AAAA_AAAA, 3, 0));
        send_command(make_command(CMD_INSERT_AT, 64'h0123_4567_89AB_CDEF, 127, 0));
        send_command(make_command(CMD_REMOVE_AT, '0, 1, 0));
    endtask

    task automatic test_reads();
        send_command(make_command(CMD_READ_FIRST, '0, 0, 0));
        send_command(make_command(CMD_READ_LAST, '0, 0, 0));
        send_command(make_command(CMD_READ_AT, '0, 2, 0));
    endtask

    task automatic test_reverse_clear();
        send_command(make_command(CMD_REVERSE, '0, 0, 0));
        send_command(make_command(CMD_READ_FIRST, '0, 0, 0));
        send_command(make_command(CMD_CLEAR, '0, 0, 0));
    endtask

    // Saturated fill, full-list append and insert, range-before-full, last read, empty fill
    task automatic test_fill_and_full();
        send_command(make_command(CMD_FILL, '0, 0, 127));
        send_command(make_command(CMD_APPEND, 64'hDEAD_BEEF_0000_0001, 0, 0));
        send_command(make_command(CMD_INSERT_AT, 64'hDEAD_BEEF_0000_0002, CAPACITY, 0));
        send_command(make_command(CMD_INSERT_AT, 64'hDEAD_BEEF_0000_0003, CAPACITY + 1, 0));
        send_command(make_command(CMD_READ_LAST, '0, 0, 0));
        send_command(make_command(CMD_FILL, '0, 0, 0));
    endtask

    task automatic test_unused_commands();
        send_command(make_command(CMD_FIRST_UNUSED, {WORD_W{1'b1}}, 127, 127));
        send_command(make_command(CMD_LAST_CODE, {WORD_W{1'b1}}, 127, 127));
    endtask

    function automatic logic [WORD_W-1:0] random_word();
        case ($urandom_range(9))
            0:       return '0;
            1:       return {WORD_W{1'b1}};
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // Random mix weighted toward legal indices, with some bad ones as noise
    task automatic test_random_traffic(input int n_items, input int in_pct,
                                       input int out_pct);
        int          pick;
        int          pos;
        int          fc;
        logic [3:0]  code;
        in_idle_pct   = in_pct;
        out_stall_pct = out_pct;
        for (int n = 0; n < n_items; n++) begin
            pick = $urandom_range(99);
            pos  = $urandom_range(127);
            fc   = 0;
            if (pick < 20) begin
                code = CMD_APPEND;
            end else if (pick < 36) begin
                code = CMD_INSERT_AT;
                if ($urandom_range(99) < 85) pos = $urandom_range(list_length);
            end else if (pick < 49) begin
                code = CMD_REMOVE_AT;
                if (list_length > 0 && $urandom_range(99) < 85)
                    pos = $urandom_range(list_length - 1);
            end else if (pick < 57) begin
                code = CMD_DROP_LAST;
            end else if (pick < 63) begin
                code = CMD_READ_FIRST;
            end else if (pick < 69) begin
                code = CMD_READ_LAST;
            end else if (pick < 82) begin
                code = CMD_READ_AT;
                if (list_length > 0 && $urandom_range(99) < 85)
                    pos = $urandom_range(list_length - 1);
            end else if (pick < 87) begin
                code = CMD_REVERSE;
            end else if (pick < 90) begin
                code = CMD_CLEAR;
            end else if (pick < 97) begin
                code = CMD_FILL;
                case ($urandom_range(19)) inside
                    0:       fc = $urandom_range(127, CAPACITY);
                    [1:3]:   fc = $urandom_range(CAPACITY - 1, 13);
                    default: fc = $urandom_range(12);
                endcase
            end else begin
                code = 4'($urandom_range(CMD_LAST_CODE, CMD_FIRST_UNUSED));
            end
            if (code != CMD_FILL && $urandom_range(3) == 0) fc = $urandom_range(127);
            send_command(make_command(code, random_word(), pos, fc));
        end
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        in_idle_pct   = 12;
        out_stall_pct = 68;
        test_empty_list();
        test_append_insert_remove();
        test_reads();
        test_reverse_clear();
        test_fill_and_full();
        test_unused_commands();

        test_random_traffic(317, 12, 68);
        test_random_traffic(317, 68, 12);
        test_random_traffic(316, 0, 0);

        // Drain outstanding results, then allow for stray output
        i_in_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (fail_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
